>>> rtl/mvc_pkg.sv
// Shared constants, register codes and the sine table for the chorus.
`default_nettype none
package mvc_pkg;

    localparam int MIX_BITS      = 16;
    localparam int VCNT_BITS     = 3;
    localparam int STEP_BITS     = 24;
    localparam int BASE_BITS     = 11;
    localparam int AMP_BITS      = 18;
    localparam int PHASE_BITS    = 32;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [CFG_IDX_BITS-1:0] REG_MIX    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_VOICES = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_STEP   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_BASE   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_AMP    = 3'd4;

    localparam logic [MIX_BITS-1:0]  MIX_FULL    = 16'd32768;
    localparam logic [MIX_BITS-1:0]  MIX_RST     = 16'd16384;
    localparam logic [VCNT_BITS-1:0] VCNT_RST    = 3'd2;
    localparam logic [STEP_BITS-1:0] STEP_RST    = 24'd44739;
    localparam logic [BASE_BITS-1:0] BASE_RST    = 11'd960;
    localparam logic [AMP_BITS-1:0]  AMP_RST     = 18'd61440;

    typedef logic signed [16:0] sine_t;

    localparam logic [15:0] SINE_QUARTER [0:64] = '{
        16'd0,     16'd804,   16'd1608,  16'd2410,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
        16'd6393,  16'd7179,  16'd7962,  16'd8739,  16'd9512,  16'd10278, 16'd11039, 16'd11793,
        16'd12539, 16'd13278, 16'd14010, 16'd14732, 16'd15446, 16'd16151, 16'd16845, 16'd17530,
        16'd18204, 16'd18867, 16'd19519, 16'd20159, 16'd20787, 16'd21402, 16'd22005, 16'd22594,
        16'd23170, 16'd23731, 16'd24279, 16'd24811, 16'd25329, 16'd25832, 16'd26318, 16'd26790,
        16'd27245, 16'd27683, 16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956,
        16'd30273, 16'd30571, 16'd30851, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971,
        16'd32137, 16'd32284, 16'd32412, 16'd32520, 16'd32609, 16'd32678, 16'd32727, 16'd32757,
        16'd32767
    };

    // one of 256 points on the full cycle, folded from the quarter wave
    function automatic sine_t sine_point(input logic [7:0] k);
        logic [6:0]  ra;
        logic [6:0]  rb;
        logic [15:0] a;
        logic [15:0] b;
        ra = {1'b0, k[5:0]};
        rb = 7'd64 - ra;
        a  = SINE_QUARTER[ra];
        b  = SINE_QUARTER[rb];
        unique case (k[7:6])
            2'd0:    sine_point = $signed({1'b0, a});
            2'd1:    sine_point = $signed({1'b0, b});
            2'd2:    sine_point = -$signed({1'b0, a});
            default: sine_point = -$signed({1'b0, b});
        endcase
    endfunction

endpackage
`default_nettype wire

>>> rtl/mvc_line_mem.sv
// Stereo delay-line memory with write pointer and fill tracking.
`default_nettype none
module mvc_line_mem #(
    parameter int DEPTH = 2048,
    parameter int ABITS = 11,
    parameter int WIDTH = 48
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             advance,
    output logic [ABITS-1:0] wr_ptr,
    input  logic             rd_en,
    input  logic [ABITS-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] q_reg;
    logic             ok_reg;
    logic [ABITS-1:0] ptr_reg;
    logic [ABITS-1:0] ptr_next;
    logic             wrapped_reg;
    logic             wrapped_next;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[ptr_reg] <= wr_data;
        end
        if (rd_en) begin
            q_reg <= mem[rd_addr];
        end
    end

    // entries never written read as zero until the line has wrapped once
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ok_reg <= 1'b0;
        end else if (rd_en) begin
            ok_reg <= wrapped_reg || (rd_addr < ptr_reg);
        end
    end

    always_comb begin
        ptr_next     = ptr_reg;
        wrapped_next = wrapped_reg;
        if (advance) begin
            if (ptr_reg == ABITS'(DEPTH - 1)) begin
                ptr_next     = '0;
                wrapped_next = 1'b1;
            end else begin
                ptr_next = ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg     <= '0;
            wrapped_reg <= 1'b0;
        end else begin
            ptr_reg     <= ptr_next;
            wrapped_reg <= wrapped_next;
        end
    end

    assign wr_ptr  = ptr_reg;
    assign rd_data = ok_reg ? q_reg : '0;

endmodule
`default_nettype wire

>>> rtl/mvc_mix.sv
// Wet/dry mix of one channel with floor division by 32768*n and saturation.
`default_nettype none
module mvc_mix #(
    parameter int SAMPLE_BITS = 24,
    parameter int MAX_VOICES  = 4,
    localparam int VB = $clog2(MAX_VOICES + 1),
    localparam int SW = SAMPLE_BITS + VB,
    localparam int MW = SAMPLE_BITS + 3,
    localparam int RW = MW + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [SAMPLE_BITS-1:0] x,
    input  logic signed [SW-1:0]          sum,
    input  logic [mvc_pkg::MIX_BITS-1:0]  mix,
    input  logic [VB-1:0]                 n,
    input  logic [RW-1:0]                 recip,
    output logic                          done,
    output logic signed [SAMPLE_BITS-1:0] y
);
    import mvc_pkg::*;

    localparam int AW = SW + 20;
    localparam int TW = AW - 15;
    localparam logic signed [SAMPLE_BITS-1:0] Y_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] Y_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic [5:0]                       vld_reg;
    logic signed [SAMPLE_BITS+17:0]   pa_reg;
    logic signed [SW+16:0]            pm_reg;
    logic signed [TW-1:0]             t_reg;
    logic [MW-1:0]                    mag_reg;
    logic                             neg_reg, neg2_reg, neg3_reg;
    logic                             shi_reg, shi2_reg, shi3_reg;
    logic                             slo_reg, slo2_reg, slo3_reg;
    logic [MW-1:0]                    mag2_reg;
    logic [MW-1:0]                    qe_reg, qe2_reg;
    logic [MW-1:0]                    r_reg;
    logic signed [SAMPLE_BITS-1:0]    y_reg;

    logic [16:0]                      dry_gain;
    logic signed [AW-1:0]             acc;
    logic signed [TW-1:0]             lim;
    logic signed [TW-1:0]             t_abs;
    logic [2*MW:0]                    qprod;
    logic [MW+VB-1:0]                 qn;
    logic                             ge;
    logic [MW-1:0]                    rem;
    logic [MW-1:0]                    q0;
    logic signed [MW:0]               qs;

    assign dry_gain = 17'd32768 - {1'b0, mix};
    assign acc      = AW'(pa_reg) * $signed({1'b0, n}) + AW'(pm_reg);
    assign lim      = $signed(TW'(n) << (SAMPLE_BITS - 1));
    assign t_abs    = t_reg[TW-1] ? -t_reg : t_reg;
    assign qprod    = mag_reg * recip;
    assign qn       = qe_reg * n;
    assign ge       = r_reg >= MW'(n);
    assign rem      = ge ? (r_reg - MW'(n)) : r_reg;
    assign q0       = qe2_reg + MW'(ge);
    assign qs       = neg3_reg ? -$signed({1'b0, q0 + MW'(rem != '0)}) : $signed({1'b0, q0});

    always_ff @(posedge aclk) begin
        pa_reg   <= x * $signed({1'b0, dry_gain});
        pm_reg   <= sum * $signed({1'b0, mix});
        t_reg    <= TW'(acc >>> 15);
        mag_reg  <= MW'(t_abs);
        neg_reg  <= t_reg[TW-1];
        shi_reg  <= t_reg >= lim;
        slo_reg  <= t_reg < -lim;
        qe_reg   <= qprod[2*MW-1:MW];
        mag2_reg <= mag_reg;
        neg2_reg <= neg_reg;
        shi2_reg <= shi_reg;
        slo2_reg <= slo_reg;
        r_reg    <= mag2_reg - MW'(qn);
        qe2_reg  <= qe_reg;
        neg3_reg <= neg2_reg;
        shi3_reg <= shi2_reg;
        slo3_reg <= slo2_reg;
        if (vld_reg[4]) begin
            if (shi3_reg) begin
                y_reg <= Y_MAX;
            end else if (slo3_reg) begin
                y_reg <= Y_MIN;
            end else begin
                y_reg <= SAMPLE_BITS'(qs);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[4:0], start};
        end
    end

    assign done = vld_reg[5];
    assign y    = y_reg;

endmodule
`default_nettype wire

>>> rtl/multi_voice_chorus.sv
// Top level of the multi-voice stereo chorus: voice sequencer, LFOs and output register.
// Each active voice steps through sine lookup, swing multiply, delay clamp, two reads of
// the single-port delay memory for the interpolation pair, and tap accumulation; the mix
// and divide pipeline then forms the output pair. A new frame is taken once the previous
// one has reached the output register, which may still wait for the sink. Unwritten
// delay-line slots read as zero through a fill pointer, so no clearing pass follows reset.
`default_nettype none
module multi_voice_chorus #(
    parameter int DELAY_DEPTH = 2048,
    parameter int MAX_VOICES  = 4,
    parameter int SAMPLE_BITS = 24,
    localparam int TDW = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [TDW-1:0]                       s_tdata,   // right_in high, left_in low
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [TDW-1:0]                       m_tdata,   // right_out high, left_out low
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mvc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [mvc_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
    import mvc_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int ABITS = $clog2(DELAY_DEPTH);
    localparam int VB    = $clog2(MAX_VOICES + 1);
    localparam int VIW   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int SW    = SB + VB;
    localparam int MW    = SB + 3;
    localparam int RW    = MW + 1;
    localparam int DELW  = ((ABITS + 8 > 19) ? ABITS + 8 : 19) + 3;
    localparam logic signed [DELW-1:0] DEL_LO = DELW'(256);
    localparam logic signed [DELW-1:0] DEL_HI = DELW'((DELAY_DEPTH - 2) * 256);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SIN  = 4'd1;
    localparam logic [3:0] ST_MUL  = 4'd2;
    localparam logic [3:0] ST_DEL  = 4'd3;
    localparam logic [3:0] ST_RA0  = 4'd4;
    localparam logic [3:0] ST_RA1  = 4'd5;
    localparam logic [3:0] ST_TAP  = 4'd6;
    localparam logic [3:0] ST_MIX  = 4'd7;
    localparam logic [3:0] ST_WAIT = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    // config
    logic [MIX_BITS-1:0]  mix_reg;
    logic [VCNT_BITS-1:0] vcnt_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [BASE_BITS-1:0] base_reg;
    logic [AMP_BITS-1:0]  amp_reg;

    // control
    logic [3:0]            state_reg, state_next;
    logic [VIW-1:0]        v_reg, v_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [PHASE_BITS-1:0] phase_reg [0:MAX_VOICES-1];

    // datapath
    logic signed [SB-1:0]   xl_reg, xr_reg;
    sine_t                  s_reg;
    logic signed [35:0]     prod_reg;
    logic signed [DELW-1:0] del_reg;
    logic [ABITS-1:0]       i0_reg;
    logic signed [SB-1:0]   x0l_reg, x0r_reg;
    logic signed [SW-1:0]   suml_reg, sumr_reg, suml_next, sumr_next;
    logic [TDW-1:0]         m_tdata_reg;

    logic [MIX_BITS-1:0]    m_eff;
    logic [VB-1:0]          n_eff;
    logic [VB-1:0]          v_cnt;
    logic                   last_voice;
    logic [RW-1:0]          recip_tbl [0:MAX_VOICES];
    logic [RW-1:0]          recip;

    logic [PHASE_BITS-1:0]  ph;
    sine_t                  s0, s1, s_val;
    logic signed [17:0]     sdiff;
    logic signed [26:0]     sfrac;
    logic signed [DELW-1:0] dsum, dclamp;
    logic [ABITS-1:0]       dint;
    logic [ABITS:0]         dsub;
    logic [ABITS-1:0]       i0, i1;
    logic [7:0]             g;
    logic [8:0]             gc;
    logic signed [SB-1:0]   x1l, x1r;
    logic signed [SB+10:0]  tapw_l, tapw_r;

    logic                   mem_wr, mem_adv, mem_rd;
    logic [ABITS-1:0]       wptr, rd_addr;
    logic [2*SB-1:0]        rd_data;

    logic                   mix_start, done_l, done_r;
    logic signed [SB-1:0]   yl, yr;

    genvar gi;
    generate
        for (gi = 0; gi <= MAX_VOICES; gi++) begin : g_recip
            localparam longint unsigned RV = (gi == 0) ? 0 : ((64'd1 << MW) / gi);
            assign recip_tbl[gi] = RW'(RV);
        end
    endgenerate

    assign m_eff = (mix_reg > MIX_FULL) ? MIX_FULL : mix_reg;
    assign n_eff = (vcnt_reg == '0) ? VB'(1) :
                   ((32'(vcnt_reg) > MAX_VOICES) ? VB'(MAX_VOICES) : VB'(vcnt_reg));
    assign recip = recip_tbl[n_eff];
    assign v_cnt = VB'(v_reg) + VB'(1);
    assign last_voice = (v_cnt == n_eff);

    // LFO sine with linear interpolation between table points
    assign ph    = phase_reg[v_reg];
    assign s0    = sine_point(ph[31:24]);
    assign s1    = sine_point(ph[31:24] + 8'd1);
    assign sdiff = 18'(s1) - 18'(s0);
    assign sfrac = sdiff * $signed({1'b0, ph[23:16]});
    assign s_val = s0 + 17'(sfrac >>> 8);

    // delay in Q.8 samples
    assign dsum   = $signed(DELW'({base_reg, 8'd0})) + DELW'(prod_reg >>> 15);
    assign dclamp = (dsum < DEL_LO) ? DEL_LO : ((dsum > DEL_HI) ? DEL_HI : dsum);

    assign dint = del_reg[ABITS+7:8];
    assign dsub = {1'b0, wptr} - {1'b0, dint};
    assign i0   = dsub[ABITS] ? ABITS'(dsub + (ABITS+1)'(DELAY_DEPTH)) : dsub[ABITS-1:0];
    assign i1   = (i0_reg == '0) ? ABITS'(DELAY_DEPTH - 1) : (i0_reg - 1'b1);

    assign g      = del_reg[7:0];
    assign gc     = 9'd256 - {1'b0, g};
    assign x1l    = rd_data[SB-1:0];
    assign x1r    = rd_data[2*SB-1:SB];
    assign tapw_l = x0l_reg * $signed({1'b0, gc}) + x1l * $signed({2'b0, g});
    assign tapw_r = x0r_reg * $signed({1'b0, gc}) + x1r * $signed({2'b0, g});
    assign suml_next = suml_reg + SW'(tapw_l >>> 8);
    assign sumr_next = sumr_reg + SW'(tapw_r >>> 8);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign mem_wr    = s_tvalid && s_tready;
    assign mem_adv   = (state_reg == ST_MIX);
    assign mem_rd    = (state_reg == ST_RA0) || (state_reg == ST_RA1);
    assign rd_addr   = (state_reg == ST_RA0) ? i0 : i1;
    assign mix_start = (state_reg == ST_MIX);

    mvc_line_mem #(
        .DEPTH (DELAY_DEPTH),
        .ABITS (ABITS),
        .WIDTH (2 * SB)
    ) u_line (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (mem_wr),
        .wr_data (s_tdata[2*SB-1:0]),
        .advance (mem_adv),
        .wr_ptr  (wptr),
        .rd_en   (mem_rd),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mvc_mix #(.SAMPLE_BITS(SB), .MAX_VOICES(MAX_VOICES)) u_mix_l (
        .aclk (aclk), .aresetn (aresetn), .start (mix_start),
        .x (xl_reg), .sum (suml_reg), .mix (m_eff), .n (n_eff), .recip (recip),
        .done (done_l), .y (yl)
    );

    mvc_mix #(.SAMPLE_BITS(SB), .MAX_VOICES(MAX_VOICES)) u_mix_r (
        .aclk (aclk), .aresetn (aresetn), .start (mix_start),
        .x (xr_reg), .sum (sumr_reg), .mix (m_eff), .n (n_eff), .recip (recip),
        .done (done_r), .y (yr)
    );

    always_comb begin
        state_next    = state_reg;
        v_next        = v_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_SIN;
                    v_next     = '0;
                end
            end
            ST_SIN:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_DEL;
            ST_DEL:  state_next = ST_RA0;
            ST_RA0:  state_next = ST_RA1;
            ST_RA1:  state_next = ST_TAP;
            ST_TAP: begin
                if (last_voice) begin
                    state_next = ST_MIX;
                end else begin
                    state_next = ST_SIN;
                    v_next     = v_reg + 1'b1;
                end
            end
            ST_MIX:  state_next = ST_WAIT;
            ST_WAIT: begin
                if (done_l) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            v_reg        <= '0;
            m_tvalid_reg <= 1'b0;
            mix_reg      <= MIX_RST;
            vcnt_reg     <= VCNT_RST;
            step_reg     <= STEP_RST;
            base_reg     <= BASE_RST;
            amp_reg      <= AMP_RST;
            for (int k = 0; k < MAX_VOICES; k++) begin
                phase_reg[k] <= (k % 2 == 1) ? 32'h8000_0000 : 32'h0;
            end
        end else begin
            state_reg    <= state_next;
            v_reg        <= v_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_MIX:    mix_reg  <= cfg_data[MIX_BITS-1:0];
                    REG_VOICES: vcnt_reg <= cfg_data[VCNT_BITS-1:0];
                    REG_STEP:   step_reg <= cfg_data[STEP_BITS-1:0];
                    REG_BASE:   base_reg <= cfg_data[BASE_BITS-1:0];
                    REG_AMP:    amp_reg  <= cfg_data[AMP_BITS-1:0];
                    default: ;
                endcase
            end
            // phase advances once the voice's taps are read
            if (state_reg == ST_TAP) begin
                phase_reg[v_reg] <= ph + PHASE_BITS'(step_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_wr) begin
            xl_reg   <= s_tdata[SB-1:0];
            xr_reg   <= s_tdata[2*SB-1:SB];
            suml_reg <= '0;
            sumr_reg <= '0;
        end else if (state_reg == ST_TAP) begin
            suml_reg <= suml_next;
            sumr_reg <= sumr_next;
        end
        if (state_reg == ST_SIN) begin
            s_reg <= s_val;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= $signed({1'b0, amp_reg}) * s_reg;
        end
        if (state_reg == ST_DEL) begin
            del_reg <= dclamp;
        end
        if (state_reg == ST_RA0) begin
            i0_reg <= i0;
        end
        if (state_reg == ST_OUT && (!m_tvalid_reg || m_tready)) begin
            m_tdata_reg <= TDW'({yr, yl});
        end
    end

    // first tap sample arrives the cycle after its read was issued
    always_ff @(posedge aclk) begin
        if (state_reg == ST_RA1) begin
            x0l_reg <= x1l;
            x0r_reg <= x1r;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        done_l |-> (state_reg == ST_WAIT) && done_r)
        else $error("mix result outside wait state");
    a_voice_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAP) |-> (v_cnt <= n_eff))
        else $error("voice counter beyond active count");
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_SIN) && (v_reg == '0))
        else $error("frame accepted without starting voice loop");
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_OUT)
        else $error("output word loaded outside output state");

endmodule
`default_nettype wire
